// ===== hdl/assert_macros.svh =====
// Assertion helpers used by the top-level file to check this block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks a property on every rising clock edge outside reset.
`define MCK_ASSERT(name, prop, msg) \
   name: assert property (@(posedge clock) disable iff (reset) (prop)) else $error(msg);

// Checks that a condition implies another in the same cycle.
`define MCK_ASSERT_IMPL(name, ante, cons, msg) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) else $error(msg);

`endif

// ===== hdl/mck_pkg.sv =====
package mck_pkg;

   localparam int CHAR_W      = 8;
   localparam int WPM_W       = 8;
   localparam int PITCH_W     = 16;
   localparam int DUR_W       = 14;
   localparam int DOT_W       = 11;
   localparam int CODE_W      = 8;
   localparam int TABLE_SIZE  = 90;
   localparam int TABLE_IDX_W = 7;
   localparam int CSR_INDEX_W = 8;
   localparam int CSR_DATA_W  = 16;
   localparam int QUEUE_DEPTH = 2;
   localparam int QUEUE_PTR_W = 1;
   localparam int QUEUE_CNT_W = 2;
   localparam int DIV_CNT_W   = 4;
   localparam int RSP_DATA_W  = 32;

   localparam logic [CSR_INDEX_W-1:0] REG_WPM   = 8'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_PITCH = 8'd1;

   localparam logic [WPM_W-1:0]   WPM_RESET   = 8'd20;
   localparam logic [PITCH_W-1:0] PITCH_RESET = 16'd440;
   localparam logic [DOT_W-1:0]   DOT_NUMER   = 11'd1200;
   localparam logic [DOT_W-1:0]   DOT_RESET   = 11'd60;

   localparam logic [CHAR_W-1:0] ASCII_SPACE = 8'd32;
   localparam logic [CHAR_W-1:0] TABLE_FIRST = 8'd33;
   localparam logic [CHAR_W-1:0] TABLE_LAST  = 8'd122;
   localparam logic [CODE_W-1:0] CODE_MARKER = 8'd1;

   localparam logic [CODE_W-1:0] CODE_TABLE [0:TABLE_SIZE-1] = '{
      8'd107, 8'd82,  8'd1,   8'd137, 8'd1,   8'd40,  8'd94,  8'd109, 8'd109, 8'd1,
      8'd42,  8'd115, 8'd97,  8'd85,  8'd50,  8'd63,  8'd62,  8'd60,  8'd56,  8'd48,
      8'd32,  8'd33,  8'd35,  8'd39,  8'd47,  8'd120, 8'd53,  8'd1,   8'd49,  8'd1,
      8'd76,  8'd69,  8'd6,   8'd17,  8'd21,  8'd9,   8'd2,   8'd20,  8'd11,  8'd16,
      8'd4,   8'd30,  8'd13,  8'd18,  8'd7,   8'd5,   8'd15,  8'd22,  8'd27,  8'd10,
      8'd8,   8'd3,   8'd12,  8'd24,  8'd14,  8'd25,  8'd29,  8'd19,  8'd1,   8'd1,
      8'd1,   8'd1,   8'd77,  8'd94,  8'd6,   8'd17,  8'd21,  8'd9,   8'd2,   8'd20,
      8'd11,  8'd16,  8'd4,   8'd30,  8'd13,  8'd18,  8'd7,   8'd5,   8'd15,  8'd22,
      8'd27,  8'd10,  8'd8,   8'd3,   8'd12,  8'd24,  8'd14,  8'd25,  8'd29,  8'd19
   };

   typedef struct packed {
      logic              is_space;
      logic [CODE_W-1:0] code;
   } cmd_type;

   typedef struct packed {
      logic               tone_on;
      logic [PITCH_W-1:0] pitch_hz;
      logic [DUR_W-1:0]   duration_ms;
      logic               last_segment;
   } seg_type;

endpackage

// ===== hdl/morse_character_keyer_top.sv =====
// Morse character keyer: turns ASCII characters into timed keying segments.
// The req channel takes one character per transfer in req_tdata. Each character
// gives up to fifteen segments on the rsp channel: tone_on in rsp_tuser, the pitch
// and the duration in milliseconds in rsp_tdata, and rsp_tlast on the closing gap.
// Characters outside the code table other than space give no segments.
// The csr channel writes the speed (index 0) or the pitch (index 1).
// A character transfer is written to the queue, popped by the sequencer, and its
// first segment registered; segments then follow one per cycle while the receiver
// takes them. The sequencer spends an idle step popping each character first.
// A two-entry queue separates the character decoder from the sequencer.
// A speed write runs a serial division for the dot length, and req_tready and
// csr_ready stay low until it completes.
// Reset restores 20 words per minute and 440 Hz, and empties the queue.
// When the receiver stalls, the current segment holds, the sequencer waits, and
// characters are taken until the queue is full.
`include "assert_macros.svh"

module morse_character_keyer_top
   import mck_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  logic [CHAR_W-1:0]      req_tdata,    // [7:0] ascii_char
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   output logic [RSP_DATA_W-1:0]  rsp_tdata,    // [15:0] pitch_hz, [29:16] duration_ms
   output logic                   rsp_tuser,    // [0] tone_on
   output logic                   rsp_tlast,
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_data
);

   logic [PITCH_W-1:0] pitch_ff, pitch_in;
   logic               div_busy;
   logic [DOT_W-1:0]   dot;
   logic               div_start;
   logic               csr_write;
   logic               push;
   cmd_type            push_cmd;
   logic               q_full;
   logic               q_not_empty;
   cmd_type            q_head;
   logic               pop;
   seg_type            seg;

   assign csr_ready = !div_busy;
   assign csr_write = csr_valid && csr_ready;
   assign div_start = csr_write && (csr_index == REG_WPM);
   assign pitch_in  = (csr_write && (csr_index == REG_PITCH)) ? csr_data : pitch_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         pitch_ff <= PITCH_RESET;
      end else begin
         pitch_ff <= pitch_in;
      end
   end

   mck_div u_div (
      .clock   (clock),
      .reset   (reset),
      .start   (div_start),
      .divisor (csr_data[WPM_W-1:0]),
      .busy    (div_busy),
      .dot     (dot)
   );

   mck_front u_front (
      .req_tvalid (req_tvalid),
      .req_tdata  (req_tdata),
      .hold       (div_busy),
      .q_full     (q_full),
      .req_tready (req_tready),
      .push       (push),
      .cmd        (push_cmd)
   );

   mck_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_cmd  (push_cmd),
      .pop       (pop),
      .full      (q_full),
      .not_empty (q_not_empty),
      .head      (q_head)
   );

   mck_back u_back (
      .clock       (clock),
      .reset       (reset),
      .q_not_empty (q_not_empty),
      .q_head      (q_head),
      .pop         (pop),
      .dot         (dot),
      .pitch       (pitch_ff),
      .rsp_tready  (rsp_tready),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_seg     (seg)
   );

   assign rsp_tdata = {2'b00, seg.duration_ms, seg.pitch_hz};
   assign rsp_tuser = seg.tone_on;
   assign rsp_tlast = seg.last_segment;

   `MCK_ASSERT_IMPL(a_silent_no_pitch, rsp_tvalid && !rsp_tuser, rsp_tdata[15:0] == 16'd0,
      "silent segment carries a pitch")
   `MCK_ASSERT_IMPL(a_tone_not_last, rsp_tvalid && rsp_tuser, !rsp_tlast,
      "tone segment marked as last")
   `MCK_ASSERT_IMPL(a_no_req_while_div, div_busy, !req_tready && !push,
      "character taken while dot length is being computed")

endmodule

// ===== hdl/mck_div.sv =====
module mck_div
   import mck_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [WPM_W-1:0] divisor,
   output logic             busy,
   output logic [DOT_W-1:0] dot
);

   logic                 busy_ff, busy_in;
   logic [DIV_CNT_W-1:0] cnt_ff, cnt_in;
   logic [WPM_W-1:0]     rem_ff, rem_in;
   logic [WPM_W-1:0]     dvs_ff, dvs_in;
   logic [DOT_W-1:0]     quo_ff, quo_in;
   logic [DOT_W-1:0]     dot_ff, dot_in;
   logic [WPM_W:0]       trial;
   logic                 qbit;

   always_comb begin
      busy_in = busy_ff;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      dvs_in  = dvs_ff;
      quo_in  = quo_ff;
      dot_in  = dot_ff;
      trial   = {rem_ff, quo_ff[DOT_W-1]};
      qbit    = (trial >= {1'b0, dvs_ff});
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         rem_in  = '0;
         dvs_in  = (divisor == '0) ? WPM_W'(1) : divisor;
         quo_in  = DOT_NUMER;
      end else if (busy_ff) begin
         rem_in = qbit ? WPM_W'(trial - {1'b0, dvs_ff}) : trial[WPM_W-1:0];
         quo_in = {quo_ff[DOT_W-2:0], qbit};
         cnt_in = cnt_ff + DIV_CNT_W'(1);
         if (cnt_ff == DIV_CNT_W'(DOT_W - 1)) begin
            busy_in = 1'b0;
            dot_in  = {quo_ff[DOT_W-2:0], qbit};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         dot_ff  <= DOT_RESET;
      end else begin
         busy_ff <= busy_in;
         dot_ff  <= dot_in;
      end
      cnt_ff <= cnt_in;
      rem_ff <= rem_in;
      dvs_ff <= dvs_in;
      quo_ff <= quo_in;
   end

   assign busy = busy_ff;
   assign dot  = dot_ff;

endmodule

// ===== hdl/mck_front.sv =====
module mck_front
   import mck_pkg::*;
(
   input  logic              req_tvalid,
   input  logic [CHAR_W-1:0] req_tdata,
   input  logic              hold,
   input  logic              q_full,
   output logic              req_tready,
   output logic              push,
   output cmd_type           cmd
);

   logic [CHAR_W-1:0]      offset;
   logic [TABLE_IDX_W-1:0] idx;
   logic                   in_table;
   logic                   is_space;

   assign req_tready = !hold && !q_full;
   assign offset     = req_tdata - TABLE_FIRST;
   assign idx        = offset[TABLE_IDX_W-1:0];
   assign in_table   = (req_tdata >= TABLE_FIRST) && (req_tdata <= TABLE_LAST);
   assign is_space   = (req_tdata == ASCII_SPACE);

   always_comb begin
      cmd.is_space = is_space;
      cmd.code     = in_table ? CODE_TABLE[idx] : CODE_MARKER;
      push         = req_tvalid && req_tready && (is_space || in_table);
   end

endmodule

// ===== hdl/mck_queue.sv =====
module mck_queue
   import mck_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  cmd_type push_cmd,
   input  logic    pop,
   output logic    full,
   output logic    not_empty,
   output cmd_type head
);

   cmd_type                mem_ff [0:QUEUE_DEPTH-1];
   logic [QUEUE_PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_CNT_W-1:0] count_ff, count_in;

   assign full      = (count_ff == QUEUE_CNT_W'(QUEUE_DEPTH));
   assign not_empty = (count_ff != '0);
   assign head      = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + QUEUE_PTR_W'(1) : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + QUEUE_PTR_W'(1) : rd_ptr_ff;
      count_in  = count_ff + QUEUE_CNT_W'(push) - QUEUE_CNT_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_cmd;
      end
   end

endmodule

// ===== hdl/mck_back.sv =====
module mck_back
   import mck_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               q_not_empty,
   input  cmd_type            q_head,
   output logic               pop,
   input  logic [DOT_W-1:0]   dot,
   input  logic [PITCH_W-1:0] pitch,
   input  logic               rsp_tready,
   output logic               rsp_tvalid,
   output seg_type            rsp_seg
);

   localparam logic [1:0] ST_IDLE  = 2'd0;
   localparam logic [1:0] ST_SPACE = 2'd1;
   localparam logic [1:0] ST_TONE  = 2'd2;
   localparam logic [1:0] ST_GAP   = 2'd3;

   logic [1:0]        state_ff, state_in;
   logic [CODE_W-1:0] code_ff, code_in;
   logic              valid_ff, valid_in;
   seg_type           seg_ff, seg_in;
   logic              adv;
   logic [DUR_W-1:0]  dot1, dot2, dot3, dot7;

   assign dot1 = {3'b000, dot};
   assign dot2 = {2'b00, dot, 1'b0};
   assign dot3 = dot2 + dot1;
   assign dot7 = {dot, 3'b000} - dot1;
   assign adv  = !valid_ff || rsp_tready;

   always_comb begin
      state_in = state_ff;
      code_in  = code_ff;
      valid_in = valid_ff && !rsp_tready;
      seg_in   = seg_ff;
      pop      = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (q_not_empty) begin
               pop      = 1'b1;
               code_in  = q_head.code;
               state_in = q_head.is_space ? ST_SPACE : ST_TONE;
            end
         end
         ST_SPACE: begin
            if (adv) begin
               valid_in = 1'b1;
               seg_in   = '{tone_on: 1'b0, pitch_hz: '0, duration_ms: dot7, last_segment: 1'b1};
               state_in = ST_IDLE;
            end
         end
         ST_TONE: begin
            if (adv) begin
               valid_in = 1'b1;
               if (code_ff > CODE_MARKER) begin
                  seg_in   = '{tone_on: 1'b1, pitch_hz: pitch,
                               duration_ms: code_ff[0] ? dot3 : dot1, last_segment: 1'b0};
                  state_in = ST_GAP;
               end else begin
                  seg_in   = '{tone_on: 1'b0, pitch_hz: '0, duration_ms: dot2,
                               last_segment: 1'b1};
                  state_in = ST_IDLE;
               end
            end
         end
         ST_GAP: begin
            if (adv) begin
               valid_in = 1'b1;
               seg_in   = '{tone_on: 1'b0, pitch_hz: '0, duration_ms: dot1, last_segment: 1'b0};
               code_in  = {1'b0, code_ff[CODE_W-1:1]};
               state_in = ST_TONE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         valid_ff <= valid_in;
      end
      code_ff <= code_in;
      seg_ff  <= seg_in;
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_seg    = seg_ff;

endmodule

// ===== test/tb_morse_character_keyer_top.sv =====
`timescale 1ns / 100ps

module tb_morse_character_keyer_top;
   import mck_pkg::*;

   localparam int WATCHDOG_LIMIT = 2000;
   localparam int SETTLE_CYCLES  = 24;
   localparam int LONG_HOLD      = 300;
   localparam int NUM_DIRECTED   = 22;

   localparam logic [7:0] MORSE_CODES [0:89] = '{
      8'd107, 8'd82,  8'd1,   8'd137, 8'd1,   8'd40,  8'd94,  8'd109, 8'd109, 8'd1,
      8'd42,  8'd115, 8'd97,  8'd85,  8'd50,  8'd63,  8'd62,  8'd60,  8'd56,  8'd48,
      8'd32,  8'd33,  8'd35,  8'd39,  8'd47,  8'd120, 8'd53,  8'd1,   8'd49,  8'd1,
      8'd76,  8'd69,  8'd6,   8'd17,  8'd21,  8'd9,   8'd2,   8'd20,  8'd11,  8'd16,
      8'd4,   8'd30,  8'd13,  8'd18,  8'd7,   8'd5,   8'd15,  8'd22,  8'd27,  8'd10,
      8'd8,   8'd3,   8'd12,  8'd24,  8'd14,  8'd25,  8'd29,  8'd19,  8'd1,   8'd1,
      8'd1,   8'd1,   8'd77,  8'd94,  8'd6,   8'd17,  8'd21,  8'd9,   8'd2,   8'd20,
      8'd11,  8'd16,  8'd4,   8'd30,  8'd13,  8'd18,  8'd7,   8'd5,   8'd15,  8'd22,
      8'd27,  8'd10,  8'd8,   8'd3,   8'd12,  8'd24,  8'd14,  8'd25,  8'd29,  8'd19
   };

   // Space, table ends, the longest code, unmapped entries, bytes outside the table.
   localparam logic [7:0] DIRECTED_CHARS [0:NUM_DIRECTED-1] = '{
      8'd32, 8'd33, 8'd122, 8'd36, 8'd35, 8'd91, 8'd0, 8'd31, 8'd123, 8'd255, 8'd127,
      8'd128, 8'd48, 8'd53, 8'd69, 8'd84, 8'd101, 8'd65, 8'd57, 8'd63, 8'd32, 8'd90
   };

   typedef struct packed {
      logic         tone_on;
      logic [15:0]  pitch_hz;
      logic [13:0]  duration_ms;
      logic         last_segment;
   } segment_type;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   logic [CHAR_W-1:0]      req_tdata = '0;
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0]  rsp_tdata;
   logic                   rsp_tuser;
   logic                   rsp_tlast;
   logic                   csr_valid = 1'b0;
   logic                   csr_ready;
   logic [CSR_INDEX_W-1:0] csr_index = '0;
   logic [CSR_DATA_W-1:0]  csr_data = '0;

   logic [7:0]  char_queue [$];
   segment_type segment_queue [$];
   logic [7:0]  keyer_wpm = 8'd20;
   logic [15:0] keyer_pitch = 16'd440;
   logic        req_fire = 1'b0;
   bit          idling_on = 1'b0;
   int          req_gap = 0;
   int          rsp_stall = 0;
   int          long_hold_reqs = 0;
   int          long_hold_seen = 0;
   int          chars_queued = 0;
   int          chars_accepted = 0;
   int          quiet_cycles = 0;
   int          mismatch_count = 0;

   morse_character_keyer_top DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   always #5ns clock = ~clock;

   function automatic void push_segment(input logic tone, input int unsigned ms,
                                        input logic last);
      segment_type seg;
      seg.tone_on      = tone;
      seg.pitch_hz     = tone ? keyer_pitch : 16'd0;
      seg.duration_ms  = ms[13:0];
      seg.last_segment = last;
      segment_queue.push_back(seg);
   endfunction

   // Expands one character into the keying segments it should produce.
   function automatic void predict_segments(input logic [7:0] ch);
      int unsigned rate;
      int unsigned dot;
      logic [7:0]  code;
      rate = (keyer_wpm == 8'd0) ? 1 : keyer_wpm;
      dot  = 1200 / rate;
      if (ch == ASCII_SPACE) begin
         push_segment(1'b0, 7 * dot, 1'b1);
      end else if (ch >= TABLE_FIRST && ch <= TABLE_LAST) begin
         code = MORSE_CODES[ch - TABLE_FIRST];
         while (code > 8'd1) begin
            push_segment(1'b1, code[0] ? 3 * dot : dot, 1'b0);
            push_segment(1'b0, dot, 1'b0);
            code = code >> 1;
         end
         push_segment(1'b0, 2 * dot, 1'b1);
      end
   endfunction

   function automatic void queue_char(input logic [7:0] ch);
      char_queue.push_back(ch);
      chars_queued++;
   endfunction

   // Mostly printable text drawn from the code table range, with some raw bytes mixed in.
   function automatic void queue_random_text(input int count);
      for (int i = 0; i < count; i++) begin
         if ($urandom_range(0, 99) < 85) begin
            queue_char(8'($urandom_range(32, 122)));
         end else begin
            queue_char(8'($urandom_range(0, 255)));
         end
      end
   endfunction

   task automatic write_csr(input logic [CSR_INDEX_W-1:0] idx, input logic [15:0] value);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic settle();
      while (chars_accepted != chars_queued || segment_queue.size() != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   always @(negedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else if (!req_tvalid || req_fire) begin
         if (req_gap > 0) begin
            req_gap--;
            req_tvalid <= 1'b0;
         end else if (char_queue.size() > 0) begin
            req_tvalid <= 1'b1;
            req_tdata  <= char_queue.pop_front();
            if (idling_on && $urandom_range(0, 5) == 0) begin
               req_gap = $urandom_range(1, 12);
            end
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   always @(negedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else if (long_hold_seen != long_hold_reqs) begin
         long_hold_seen = long_hold_reqs;
         rsp_stall = LONG_HOLD;
         rsp_tready <= 1'b0;
      end else if (rsp_stall > 0) begin
         rsp_stall--;
         rsp_tready <= 1'b0;
      end else if (idling_on && $urandom_range(0, 7) == 0) begin
         rsp_stall = $urandom_range(0, 11);
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   always @(posedge clock) begin
      segment_type got;
      segment_type want;
      if (reset) begin
         req_fire <= 1'b0;
      end else begin
         req_fire <= req_tvalid && req_tready;
         if (csr_valid && csr_ready) begin
            if (csr_index == REG_WPM) begin
               keyer_wpm = csr_data[7:0];
            end else if (csr_index == REG_PITCH) begin
               keyer_pitch = csr_data;
            end
         end
         if (req_tvalid && req_tready) begin
            chars_accepted++;
            predict_segments(req_tdata);
         end
         if (rsp_tvalid && rsp_tready) begin
            got.tone_on      = rsp_tuser;
            got.pitch_hz     = rsp_tdata[15:0];
            got.duration_ms  = rsp_tdata[29:16];
            got.last_segment = rsp_tlast;
            if (segment_queue.size() == 0) begin
               $error("segment transfer with none expected");
               mismatch_count++;
            end else begin
               want = segment_queue.pop_front();
               if (got.tone_on !== want.tone_on) begin
                  $error("tone_on: expected %0d, got %0d", want.tone_on, got.tone_on);
                  mismatch_count++;
               end
               if (got.pitch_hz !== want.pitch_hz) begin
                  $error("pitch_hz: expected %0d, got %0d", want.pitch_hz, got.pitch_hz);
                  mismatch_count++;
               end
               if (got.duration_ms !== want.duration_ms) begin
                  $error("duration_ms: expected %0d, got %0d",
                         want.duration_ms, got.duration_ms);
                  mismatch_count++;
               end
               if (got.last_segment !== want.last_segment) begin
                  $error("last_segment: expected %0d, got %0d",
                         want.last_segment, got.last_segment);
                  mismatch_count++;
               end
            end
         end
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)
               || (csr_valid && csr_ready)) begin
            quiet_cycles = 0;
         end else begin
            quiet_cycles++;
         end
         if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
         end
      end
   end

   initial begin
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(posedge clock);
      idling_on = 1'b1;
      for (int i = 0; i < NUM_DIRECTED; i++) queue_char(DIRECTED_CHARS[i]);
      settle();

      write_csr(REG_WPM, 16'd0);
      write_csr(REG_PITCH, 16'd0);
      write_csr(8'hFF, 16'hFFFF);
      @(posedge clock);
      queue_random_text(40);
      settle();

      // The receiver holds off while the sender keeps offering characters.
      write_csr(REG_WPM, 16'hFF01);
      write_csr(REG_PITCH, 16'hFFFF);
      write_csr(8'($urandom_range(2, 254)), 16'($urandom));
      @(posedge clock);
      long_hold_reqs++;
      queue_random_text(40);
      settle();

      write_csr(REG_WPM, 16'd255);
      write_csr(REG_PITCH, 16'($urandom_range(1, 65534)));
      @(posedge clock);
      queue_random_text(50);
      settle();

      write_csr(REG_WPM, {8'($urandom), 8'($urandom_range(2, 254))});
      write_csr(REG_PITCH, 16'($urandom));
      @(posedge clock);
      queue_random_text(60);
      settle();

      write_csr(REG_WPM, 16'd20);
      write_csr(REG_PITCH, 16'($urandom));
      @(posedge clock);
      idling_on = 1'b0;
      queue_random_text(60);
      settle();

      if (mismatch_count == 0 && segment_queue.size() == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule

// ===== files.f =====
+incdir+hdl
hdl/mck_pkg.sv
hdl/mck_div.sv
hdl/mck_front.sv
hdl/mck_queue.sv
hdl/mck_back.sv
hdl/morse_character_keyer_top.sv
test/tb_morse_character_keyer_top.sv
